### hdl/sco_pkg.sv
// ----------------------------------------------------------------------------
// Swept circle overlap package
// Default formats and shared helpers for the swept circle overlap test.
// ----------------------------------------------------------------------------
package sco_pkg;

    // Default coordinate and projection formats.
    localparam int COORD_WIDTH_DEF     = 24;
    localparam int COORD_FRAC_BITS_DEF = 8;
    localparam int T_FRAC_BITS_DEF     = 16;

    // Threshold at or below which a sweep counts as a point: 0.0001 in squared units.
    function automatic longint sweep_eps(input int frac_bits);
        sweep_eps = longint'((64'd1 << (2 * frac_bits)) / 64'd10000);
    endfunction

endpackage

### hdl/sco_prep.sv
// ----------------------------------------------------------------------------
// Swept circle overlap front end
// Differences, products, sums and projection classification ahead of the
// divider chain. Four register stages.
// ----------------------------------------------------------------------------
module sco_prep #(
    parameter int COORD_WIDTH     = sco_pkg::COORD_WIDTH_DEF,
    parameter int COORD_FRAC_BITS = sco_pkg::COORD_FRAC_BITS_DEF,
    parameter int DW              = COORD_WIDTH + 1,
    parameter int SW              = 2 * DW + 1,
    parameter int SBW             = 4 * DW + SW + 2 * COORD_WIDTH + 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_moving_radius,
    input  logic signed [COORD_WIDTH-1:0] i_target_x,
    input  logic signed [COORD_WIDTH-1:0] i_target_y,
    input  logic signed [COORD_WIDTH-1:0] i_target_radius,
    output logic                          o_valid,
    output logic        [SW-1:0]          o_rem,
    output logic        [SW-1:0]          o_len2,
    output logic        [SBW-1:0]         o_side
);
    import sco_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int PW  = 2 * DW;
    localparam int RW  = 2 * CW;
    localparam logic [SW-1:0] EPS = SW'(sweep_eps(COORD_FRAC_BITS));

    logic [3:0] r_vld;

    // Stage 1 registers
    logic signed [DW-1:0] r_wx, r_wy, r_dx, r_dy, r_ex, r_ey;
    logic        [CW-1:0] r_rad;
    // Stage 2 registers
    logic signed [DW-1:0] r2_wx, r2_wy, r2_dx, r2_dy;
    logic signed [PW-1:0] r_wx2, r_wy2, r_pdx, r_pdy, r_ex2, r_ey2;
    logic        [RW-1:0] r_rad2;
    // Stage 3 registers
    logic signed [DW-1:0] r3_wx, r3_wy, r3_dx, r3_dy;
    logic signed [SW-1:0] r_len2, r_dot, r_dend;
    logic        [RW-1:0] r3_rad2;

    logic [CW-2:0] n_radm, n_radt;

    // Negative radii count as zero.
    always_comb begin
        n_radm = i_moving_radius[CW-1] ? '0 : i_moving_radius[CW-2:0];
        n_radt = i_target_radius[CW-1] ? '0 : i_target_radius[CW-2:0];
    end

    // Valid flags of the four stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    // Payload path.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_wx  <= DW'(i_end_x) - DW'(i_start_x);
            r_wy  <= DW'(i_end_y) - DW'(i_start_y);
            r_dx  <= DW'(i_target_x) - DW'(i_start_x);
            r_dy  <= DW'(i_target_y) - DW'(i_start_y);
            r_ex  <= DW'(i_target_x) - DW'(i_end_x);
            r_ey  <= DW'(i_target_y) - DW'(i_end_y);
            r_rad <= CW'(n_radm) + CW'(n_radt);

            r2_wx  <= r_wx;
            r2_wy  <= r_wy;
            r2_dx  <= r_dx;
            r2_dy  <= r_dy;
            r_wx2  <= PW'(r_wx * r_wx);
            r_wy2  <= PW'(r_wy * r_wy);
            r_pdx  <= PW'(r_dx * r_wx);
            r_pdy  <= PW'(r_dy * r_wy);
            r_ex2  <= PW'(r_ex * r_ex);
            r_ey2  <= PW'(r_ey * r_ey);
            r_rad2 <= RW'(r_rad * r_rad);

            r3_wx   <= r2_wx;
            r3_wy   <= r2_wy;
            r3_dx   <= r2_dx;
            r3_dy   <= r2_dy;
            r_len2  <= SW'(r_wx2) + SW'(r_wy2);
            r_dot   <= SW'(r_pdx) + SW'(r_pdy);
            r_dend  <= SW'(r_ex2) + SW'(r_ey2);
            r3_rad2 <= r_rad2;

            // Classify the projection: before the start, past the end, or inside.
            o_rem  <= r_dot;
            o_len2 <= r_len2;
            o_side <= {r3_wx, r3_wy, r3_dx, r3_dy, r_dend, r3_rad2,
                       ($unsigned(r_len2) <= EPS), (r_dot <= 0), (r_len2 <= r_dot)};
        end
    end

    assign o_valid = r_vld[3];

endmodule

### hdl/sco_div_cell.sv
// ----------------------------------------------------------------------------
// Swept circle overlap divider cell
// One restoring division step: yields one bit of t and hands the partial
// remainder and the item's other data on to the next cell.
// ----------------------------------------------------------------------------
module sco_div_cell #(
    parameter int SW  = 2 * sco_pkg::COORD_WIDTH_DEF + 3,
    parameter int TW  = sco_pkg::T_FRAC_BITS_DEF + 1,
    parameter int SBW = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  logic [SW-1:0]  i_rem,
    input  logic [SW-1:0]  i_len2,
    input  logic [TW-1:0]  i_quo,
    input  logic [SBW-1:0] i_side,
    output logic           o_valid,
    output logic [SW-1:0]  o_rem,
    output logic [SW-1:0]  o_len2,
    output logic [TW-1:0]  o_quo,
    output logic [SBW-1:0] o_side
);
    logic [SW-1:0] n_shift;
    logic          n_bit;

    // Shift the remainder and try the subtraction.
    always_comb begin
        n_shift = {i_rem[SW-2:0], 1'b0};
        n_bit   = (n_shift >= i_len2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_adv) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_rem  <= n_bit ? n_shift - i_len2 : n_shift;
            o_len2 <= i_len2;
            o_quo  <= {i_quo[TW-2:0], n_bit};
            o_side <= i_side;
        end
    end

endmodule

### hdl/sco_finish.sv
// ----------------------------------------------------------------------------
// Swept circle overlap back end
// Clamps t, forms the closest point, squares the distance and compares it
// with the squared combined radius. The last stage is the output register.
// ----------------------------------------------------------------------------
module sco_finish #(
    parameter int COORD_WIDTH = sco_pkg::COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = sco_pkg::T_FRAC_BITS_DEF,
    parameter int DW          = COORD_WIDTH + 1,
    parameter int SW          = 2 * DW + 1,
    parameter int TW          = T_FRAC_BITS + 1,
    parameter int SBW         = 4 * DW + SW + 2 * COORD_WIDTH + 3
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  logic [TW-1:0]  i_quo,
    input  logic [SBW-1:0] i_side,
    output logic           o_valid,
    output logic           o_overlap
);
    localparam int CW   = COORD_WIDTH;
    localparam int RW   = 2 * CW;
    localparam int PXW  = DW + TW;
    localparam int EW   = DW + 1;
    localparam int QW   = 2 * EW;
    localparam int CMPW = QW + 1;
    localparam logic [PXW-1:0] HALF = PXW'(1) << (T_FRAC_BITS - 1);
    localparam int O_R2 = 3;
    localparam int O_DE = O_R2 + RW;
    localparam int O_DY = O_DE + SW;
    localparam int O_DX = O_DY + DW;
    localparam int O_WY = O_DX + DW;
    localparam int O_WX = O_WY + DW;

    logic signed [DW-1:0] n_wx, n_wy, n_dx, n_dy;
    logic        [DW-1:0] n_mwx, n_mwy;
    logic        [TW-1:0] n_t;

    logic [2:0] r_vld;

    // Stage 1
    logic        [PXW-1:0] r_px, r_py;
    logic                  r_sx, r_sy;
    logic signed [DW-1:0]  r_dx, r_dy;
    logic        [SW-1:0]  r_dend;
    logic        [RW-1:0]  r_rad2;
    logic                  r_short;
    // Stage 2
    logic signed [EW-1:0]  r_ex, r_ey;
    logic        [SW-1:0]  r2_dend;
    logic        [RW-1:0]  r2_rad2;
    logic                  r2_short;
    // Stage 3
    logic signed [QW-1:0]  r_ex2, r_ey2;
    logic        [SW-1:0]  r3_dend;
    logic        [RW-1:0]  r3_rad2;
    logic                  r3_short;

    logic [DW-1:0]         n_stx, n_sty;
    logic signed [EW-1:0]  n_stepx, n_stepy;
    logic [CMPW-1:0]       n_dist;

    // Unpack the item and clamp t to [0, 1].
    always_comb begin
        n_wx  = $signed(i_side[O_WX +: DW]);
        n_wy  = $signed(i_side[O_WY +: DW]);
        n_dx  = $signed(i_side[O_DX +: DW]);
        n_dy  = $signed(i_side[O_DY +: DW]);
        n_mwx = n_wx[DW-1] ? DW'(-n_wx) : DW'(n_wx);
        n_mwy = n_wy[DW-1] ? DW'(-n_wy) : DW'(n_wy);
        if (i_side[1]) begin
            n_t = '0;
        end else if (i_side[0]) begin
            n_t = TW'(1) << T_FRAC_BITS;
        end else begin
            n_t = i_quo;
        end
    end

    // Round the step to the nearest unit, ties away from zero.
    always_comb begin
        n_stx   = DW'((r_px + HALF) >> T_FRAC_BITS);
        n_sty   = DW'((r_py + HALF) >> T_FRAC_BITS);
        n_stepx = r_sx ? -$signed({1'b0, n_stx}) : $signed({1'b0, n_stx});
        n_stepy = r_sy ? -$signed({1'b0, n_sty}) : $signed({1'b0, n_sty});
        n_dist  = CMPW'($unsigned(r_ex2)) + CMPW'($unsigned(r_ey2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else if (i_adv) begin
            r_vld   <= {r_vld[1:0], i_valid};
            o_valid <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_px    <= PXW'(n_mwx) * PXW'(n_t);
            r_py    <= PXW'(n_mwy) * PXW'(n_t);
            r_sx    <= n_wx[DW-1];
            r_sy    <= n_wy[DW-1];
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_dend  <= i_side[O_DE +: SW];
            r_rad2  <= i_side[O_R2 +: RW];
            r_short <= i_side[2];

            r_ex     <= EW'(r_dx) - n_stepx;
            r_ey     <= EW'(r_dy) - n_stepy;
            r2_dend  <= r_dend;
            r2_rad2  <= r_rad2;
            r2_short <= r_short;

            r_ex2    <= QW'(r_ex * r_ex);
            r_ey2    <= QW'(r_ey * r_ey);
            r3_dend  <= r2_dend;
            r3_rad2  <= r2_rad2;
            r3_short <= r2_short;

            // A short sweep is tested against the end point alone.
            o_overlap <= r3_short ? (CMPW'(r3_dend) <= CMPW'(r3_rad2))
                                  : (n_dist <= CMPW'(r3_rad2));
        end
    end

endmodule

### hdl/swept_circle_overlap_test.sv
// ----------------------------------------------------------------------------
// Swept circle overlap test
// Tests a circle swept along a segment against a stationary circle.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall with the eight coordinate and radius
// fields; a transfer happens at a clock edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall with the single overlap flag.
// Every input transfer yields exactly one output transfer, in order.
// The pipeline holds four front stages, one divider cell per bit of t, and
// four back stages ending in the output register. One item is taken every
// cycle while the output flows.
// When the receiver stalls with a result waiting, that result moves into a
// one-entry hold register and the pipeline then freezes, with o_in_stall
// raised, until the held result is taken. o_in_stall comes straight from
// that register, so it never depends on i_out_stall in the same cycle.
// Reset clears every stage's valid flag and the hold register; no result
// appears until an item has been taken after reset.
// ----------------------------------------------------------------------------
module swept_circle_overlap_test #(
    parameter int COORD_WIDTH     = sco_pkg::COORD_WIDTH_DEF,
    parameter int COORD_FRAC_BITS = sco_pkg::COORD_FRAC_BITS_DEF,
    parameter int T_FRAC_BITS     = sco_pkg::T_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_moving_radius,
    input  logic signed [COORD_WIDTH-1:0] i_target_x,
    input  logic signed [COORD_WIDTH-1:0] i_target_y,
    input  logic signed [COORD_WIDTH-1:0] i_target_radius,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_overlap
);
    localparam int DW  = COORD_WIDTH + 1;
    localparam int SW  = 2 * DW + 1;
    localparam int TW  = T_FRAC_BITS + 1;
    localparam int SBW = 4 * DW + SW + 2 * COORD_WIDTH + 3;

    logic                adv;
    logic                vld  [T_FRAC_BITS+1];
    logic [SW-1:0]       rem  [T_FRAC_BITS+1];
    logic [SW-1:0]       len2 [T_FRAC_BITS+1];
    logic [TW-1:0]       quo  [T_FRAC_BITS+1];
    logic [SBW-1:0]      side [T_FRAC_BITS+1];
    logic                fin_valid;
    logic                fin_overlap;
    logic                r_skid_full;
    logic                r_skid_overlap;

    // The pipeline advances unless a result is parked in the hold register.
    assign adv        = !r_skid_full;
    assign o_in_stall = r_skid_full;
    assign quo[0]     = '0;

    // The held result goes out first; otherwise the pipeline output is shown.
    assign o_out_valid = r_skid_full || fin_valid;
    assign o_overlap   = r_skid_full ? r_skid_overlap : fin_overlap;

    // Park a stalled result so that the input stall comes from a register, not from i_out_stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_full <= 1'b0;
        end else if (r_skid_full) begin
            r_skid_full <= i_out_stall;
        end else begin
            r_skid_full <= fin_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_full) begin
            r_skid_overlap <= fin_overlap;
        end
    end

    sco_prep #(
        .COORD_WIDTH     (COORD_WIDTH),
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .DW              (DW),
        .SW              (SW),
        .SBW             (SBW)
    ) u_prep (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (adv),
        .i_valid         (i_in_valid),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_moving_radius (i_moving_radius),
        .i_target_x      (i_target_x),
        .i_target_y      (i_target_y),
        .i_target_radius (i_target_radius),
        .o_valid         (vld[0]),
        .o_rem           (rem[0]),
        .o_len2          (len2[0]),
        .o_side          (side[0])
    );

    // Divider chain: one cell per fraction bit of t.
    for (genvar g = 0; g < T_FRAC_BITS; g++) begin : g_cell
        sco_div_cell #(
            .SW  (SW),
            .TW  (TW),
            .SBW (SBW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (vld[g]),
            .i_rem   (rem[g]),
            .i_len2  (len2[g]),
            .i_quo   (quo[g]),
            .i_side  (side[g]),
            .o_valid (vld[g+1]),
            .o_rem   (rem[g+1]),
            .o_len2  (len2[g+1]),
            .o_quo   (quo[g+1]),
            .o_side  (side[g+1])
        );
    end

    sco_finish #(
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS),
        .DW          (DW),
        .SW          (SW),
        .TW          (TW),
        .SBW         (SBW)
    ) u_finish (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_valid   (vld[T_FRAC_BITS]),
        .i_quo     (quo[T_FRAC_BITS]),
        .i_side    (side[T_FRAC_BITS]),
        .o_valid   (fin_valid),
        .o_overlap (fin_overlap)
    );

endmodule

### hdl/sco_checker.sv
// ----------------------------------------------------------------------------
// Swept circle overlap checker
// Port-level checks of flow control and reset, bound to the top level.
// ----------------------------------------------------------------------------
module sco_port_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_overlap
);

    // The input side only stalls while a result is waiting at the output.
    a_stall_link : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result waiting");

    // A held result stays on the port unchanged.
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_overlap))
        else $error("held result changed");

    // Reset empties the pipeline.
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

endmodule

bind swept_circle_overlap_test sco_port_checker u_sco_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_overlap   (o_overlap)
);

### tb/sco_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept circle overlap checker
// Watches both channels, predicts the overlap flag of every accepted input
// transfer in exact integer arithmetic and compares it with the output.
// ----------------------------------------------------------------------------
module sco_checker #(
    parameter int CW = sco_pkg::COORD_WIDTH_DEF,
    parameter int CF = sco_pkg::COORD_FRAC_BITS_DEF,
    parameter int TF = sco_pkg::T_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic signed [CW-1:0] i_start_x,
    input  logic signed [CW-1:0] i_start_y,
    input  logic signed [CW-1:0] i_end_x,
    input  logic signed [CW-1:0] i_end_y,
    input  logic signed [CW-1:0] i_moving_radius,
    input  logic signed [CW-1:0] i_target_x,
    input  logic signed [CW-1:0] i_target_y,
    input  logic signed [CW-1:0] i_target_radius,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_overlap,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef logic signed [127:0] wide_t;

    bit overlap_queue[$];

    // Rounded v * t / 2^TF, ties away from zero.
    function automatic wide_t step_along(wide_t v, wide_t t);
        wide_t m;
        wide_t p;
        m = (v < 0) ? -v : v;
        p = (m * t + (wide_t'(1) <<< (TF - 1))) >>> TF;
        return (v < 0) ? -p : p;
    endfunction

    // Exact overlap prediction for one swept circle and one stationary circle.
    function automatic bit predict_overlap(wide_t sx, wide_t sy, wide_t ex, wide_t ey,
                                           wide_t rm, wide_t tx, wide_t ty, wide_t rt);
        wide_t rad, wx, wy, dx, dy, len2, dot, t, dist2, qx, qy, eps;
        rad  = (rm > 0 ? rm : 0) + (rt > 0 ? rt : 0);
        wx   = ex - sx;
        wy   = ey - sy;
        dx   = tx - sx;
        dy   = ty - sy;
        len2 = wx * wx + wy * wy;
        eps  = (wide_t'(1) <<< (2 * CF)) / 10000;
        if (len2 <= eps) begin
            qx = tx - ex;
            qy = ty - ey;
        end else begin
            dot = dx * wx + dy * wy;
            if (dot <= 0) begin
                t = 0;
            end else if (dot >= len2) begin
                t = wide_t'(1) <<< TF;
            end else begin
                t = (dot <<< TF) / len2;
            end
            qx = dx - step_along(wx, t);
            qy = dy - step_along(wy, t);
        end
        dist2 = qx * qx + qy * qy;
        return dist2 <= rad * rad;
    endfunction

    // Predict on every input transfer, compare on every output transfer.
    always @(posedge i_clk) begin
        bit want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                overlap_queue.push_back(predict_overlap(i_start_x, i_start_y, i_end_x,
                    i_end_y, i_moving_radius, i_target_x, i_target_y, i_target_radius));
            end
            if (i_out_valid && !i_out_stall) begin
                if (overlap_queue.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("unexpected result transfer: overlap=%0b", i_overlap);
                    end
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = overlap_queue.pop_front();
                    if (want !== i_overlap) begin
                        if (o_fail_count < 10) begin
                            $display("overlap mismatch: expected %0b, got %0b",
                                     want, i_overlap);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = overlap_queue.size();
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept circle overlap testbench
// Drives directed and random circle pairs under varying idling on both
// channels; the checker predicts and compares each overlap flag.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CW = sco_pkg::COORD_WIDTH_DEF;
    localparam int N_RANDOM = 1600;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    logic signed [CW-1:0] sx, sy, ex, ey, rm, tx, ty, rt;
    logic o_out_valid;
    logic i_out_stall;
    logic o_overlap;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;

    swept_circle_overlap_test u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_start_x(sx), .i_start_y(sy), .i_end_x(ex), .i_end_y(ey),
        .i_moving_radius(rm), .i_target_x(tx), .i_target_y(ty),
        .i_target_radius(rt),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_overlap(o_overlap)
    );

    sco_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_start_x(sx), .i_start_y(sy), .i_end_x(ex), .i_end_y(ey),
        .i_moving_radius(rm), .i_target_x(tx), .i_target_y(ty),
        .i_target_radius(rt),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_overlap(o_overlap),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver stalls at random at the current rate.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Present one transfer, idling first at random, and hold it until taken.
    task automatic send_pair(input logic signed [CW-1:0] a, b, c, d, e, f, g, h);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        sx <= a; sy <= b; ex <= c; ey <= d; rm <= e; tx <= f; ty <= g; rt <= h;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    function automatic logic signed [CW-1:0] any_coord();
        return CW'($urandom);
    endfunction

    // Random pair; mostly geometry near the sweep so both outcomes occur.
    task automatic send_random();
        logic signed [CW-1:0] ax, ay, bx, by, cx, cy, r1, r2;
        int span;
        int kind;
        kind = $urandom_range(9);
        if (kind < 2) begin
            send_pair(any_coord(), any_coord(), any_coord(), any_coord(),
                      any_coord(), any_coord(), any_coord(), any_coord());
        end else begin
            span = (kind < 4) ? 4 : (kind < 7 ? 4000 : 400000);
            ax = any_coord() >>> $urandom_range(16);
            ay = any_coord() >>> $urandom_range(16);
            bx = ax + CW'(int'($urandom_range(2 * span)) - span);
            by = ay + CW'(int'($urandom_range(2 * span)) - span);
            cx = ax + CW'(int'($urandom_range(4 * span)) - span);
            cy = ay + CW'(int'($urandom_range(4 * span)) - span);
            r1 = CW'(int'($urandom_range(span)) - span / 8);
            r2 = CW'(int'($urandom_range(span)) - span / 8);
            send_pair(ax, ay, bx, by, r1, cx, cy, r2);
        end
    endtask

    initial begin
        localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
        localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        {sx, sy, ex, ey, rm, tx, ty, rt} = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero radii, short sweep, clamps, extremes, boundary.
        send_pair(0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(0, 0, 0, 0, 0, 1, 0, 0);
        send_pair(0, 0, 2, 1, 0, 2, 1, 0);
        send_pair(0, 0, 2, 2, 0, 2, 2, 0);
        send_pair(0, 0, 3, 0, 0, 3, 0, 0);
        send_pair(0, 0, 1000, 0, 50, -100, 0, 50);
        send_pair(0, 0, 1000, 0, 50, -101, 0, 50);
        send_pair(0, 0, 1000, 0, 50, 1100, 0, 50);
        send_pair(0, 0, 1000, 0, 50, 1101, 0, 50);
        send_pair(0, 0, 1000, 0, -5, 500, 100, 100);
        send_pair(0, 0, 1000, 0, -5, 500, 101, 100);
        send_pair(0, 0, 1000, 3, 0, 333, 1, 0);
        send_pair(MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, MAXV);
        send_pair(MINV, MINV, MAXV, MAXV, 0, 0, 0, 0);
        send_pair(MAXV, MINV, MINV, MAXV, MINV, MAXV, MAXV, MINV);
        send_pair(MAXV, MAXV, MINV, MINV, 1, MAXV, MINV, 1);
        send_pair(-1, -1, -1, -1, -1, -1, -1, -1);
        send_pair(MAXV, MAXV, MAXV, MAXV, 0, MINV, MINV, 0);
        send_pair(0, 0, -7, 5, 3, -3, 2, 0);

        // Random part in three idling phases.
        send_idle_pct = 17;
        recv_idle_pct = 58;
        repeat (N_RANDOM / 3) send_random();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        // Hold off until every expected result is back.
        while (pending != 0) @(posedge i_clk);
        send_idle_pct = 58;
        recv_idle_pct = 17;
        repeat (N_RANDOM / 3) send_random();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (N_RANDOM / 3) send_random();
        i_in_valid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
hdl/sco_pkg.sv
hdl/sco_prep.sv
hdl/sco_div_cell.sv
hdl/sco_finish.sv
hdl/swept_circle_overlap_test.sv
hdl/sco_checker.sv
tb/sco_checker.sv
tb/testbench.sv
